### design/ppt_pkg.sv
// Shared widths, codes and controller/datapath interface types for the timer table.
`default_nettype none

package ppt_pkg;

    localparam int PPT_SLOTS = 16;

    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 8;
    localparam int PRIO_W   = 16;
    localparam int PERIOD_W = 32;
    localparam int KIND_W   = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REGISTER = 2'd0,
        FUNC_TICK     = 2'd1,
        FUNC_CLEAR    = 2'd2
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_FIRED      = 3'd2,
        KIND_NONE       = 3'd3,
        KIND_CLEARED    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        IDX_HOLD       = 3'd0,
        IDX_LOAD_COUNT = 3'd1,
        IDX_CLEAR      = 3'd2,
        IDX_DEC        = 3'd3,
        IDX_INC        = 3'd4
    } t_idx_op;

    typedef enum logic [1:0] {
        WR_NEW   = 2'd0,
        WR_SHIFT = 2'd1,
        WR_TICK  = 2'd2
    } t_wr_sel;

    typedef struct packed {
        logic    latch;
        t_idx_op idx_op;
        logic    rd_en;
        logic    rd_below;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_clr;
        logic    pend_clr;
        logic    pend_load;
        logic    push;
        t_kind   push_kind;
        logic    push_last;
        logic    push_pend;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic idx_last;
        logic idx_one;
        logic prio_ge;
        logic rem_zero;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### design/ppt_ifs.sv
// Valid/ready channel interfaces for the command and result beats.
`default_nettype none

interface ppt_cmd_if import ppt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TAG_W-1:0]    handler_id;
    logic [PRIO_W-1:0]   prio;
    logic [PERIOD_W-1:0] period_ticks;

    modport source (output valid, func, handler_id, prio, period_ticks, input ready);
    modport sink   (input valid, func, handler_id, prio, period_ticks, output ready);
endinterface

interface ppt_res_if import ppt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [TAG_W-1:0]  fired_id;
    logic              last;

    modport source (output valid, result_kind, fired_id, last, input ready);
    modport sink   (input valid, result_kind, fired_id, last, output ready);
endinterface

`default_nettype wire

### design/ppt_ctrl.sv
// Sequencer for insert, tick sweep and clear; drives datapath commands.
`default_nettype none

module ppt_ctrl import ppt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [FUNC_W-1:0] i_func,
    output logic              o_ready,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_EVAL,
        S_INS_PUT,
        S_TK_EVAL,
        S_TK_END,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    case (t_func'(i_func))
                        FUNC_REGISTER: begin
                            o_cmd.latch = 1'b1;
                            if (i_stat.full) begin
                                n_kind  = KIND_FULL;
                                n_state = S_RESULT;
                            end else begin
                                o_cmd.idx_op = IDX_LOAD_COUNT;
                                if (i_stat.count_zero) begin
                                    n_state = S_INS_PUT;
                                end else begin
                                    // fetch the current tail entry
                                    o_cmd.rd_en    = 1'b1;
                                    o_cmd.rd_below = 1'b1;
                                    n_state        = S_INS_EVAL;
                                end
                            end
                        end
                        FUNC_TICK: begin
                            if (i_stat.count_zero) begin
                                n_kind  = KIND_NONE;
                                n_state = S_RESULT;
                            end else begin
                                o_cmd.idx_op   = IDX_CLEAR;
                                o_cmd.rd_en    = 1'b1;
                                o_cmd.pend_clr = 1'b1;
                                n_state        = S_TK_EVAL;
                            end
                        end
                        FUNC_CLEAR: begin
                            o_cmd.cnt_clr = 1'b1;
                            n_kind        = KIND_CLEARED;
                            n_state       = S_RESULT;
                        end
                        default: begin
                            // unused code: dropped, no beat
                        end
                    endcase
                end
            end
            S_INS_EVAL: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.prio_ge) begin
                    // move entry up one slot, keep walking down
                    o_cmd.wr_sel = WR_SHIFT;
                    o_cmd.idx_op = IDX_DEC;
                    if (i_stat.idx_one) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.rd_below = 1'b1;
                    end
                end else begin
                    o_cmd.wr_sel  = WR_NEW;
                    o_cmd.cnt_inc = 1'b1;
                    n_kind        = KIND_REGISTERED;
                    n_state       = S_RESULT;
                end
            end
            S_INS_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_NEW;
                o_cmd.cnt_inc = 1'b1;
                n_kind        = KIND_REGISTERED;
                n_state       = S_RESULT;
            end
            S_TK_EVAL: begin
                // a second firing needs the held one sent out first
                if (!(i_stat.rem_zero && i_stat.pend_valid && !i_stat.out_free)) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_TICK;
                    if (i_stat.rem_zero) begin
                        o_cmd.pend_load = 1'b1;
                        if (i_stat.pend_valid) begin
                            o_cmd.push      = 1'b1;
                            o_cmd.push_kind = KIND_FIRED;
                            o_cmd.push_pend = 1'b1;
                        end
                    end
                    if (i_stat.idx_last) begin
                        n_state = S_TK_END;
                    end else begin
                        o_cmd.idx_op = IDX_INC;
                        o_cmd.rd_en  = 1'b1;
                    end
                end
            end
            S_TK_END: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    o_cmd.push_pend = i_stat.pend_valid;
                    o_cmd.push_kind = i_stat.pend_valid ? KIND_FIRED : KIND_NONE;
                    o_cmd.pend_clr  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    o_cmd.push_kind = r_kind;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_REGISTERED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

### design/ppt_dpath.sv
// Slot memory, entry count, sweep index, pending-fire holder and result register.
`default_nettype none

module ppt_dpath import ppt_pkg::*; #(
    parameter int SLOTS = PPT_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [TAG_W-1:0]    i_handler_id,
    input  logic [PRIO_W-1:0]   i_prio,
    input  logic [PERIOD_W-1:0] i_period_ticks,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [KIND_W-1:0]   o_result_kind,
    output logic [TAG_W-1:0]    o_fired_id,
    output logic                o_last
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remaining;
    } t_entry;

    t_entry r_mem [SLOTS];
    t_entry r_rd;
    t_entry w_wr_data;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    logic [CW-1:0] w_rd_idx;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    logic [TAG_W-1:0]    r_tag;
    logic [PRIO_W-1:0]   r_prio;
    logic [PERIOD_W-1:0] r_period;

    logic             r_pend_valid;
    logic [TAG_W-1:0] r_pend_tag;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [TAG_W-1:0]  r_out_id;
    logic              r_out_last;
    logic              w_out_free;

    always_comb begin
        case (i_cmd.idx_op)
            IDX_LOAD_COUNT: n_idx = r_count;
            IDX_CLEAR:      n_idx = '0;
            IDX_DEC:        n_idx = r_idx - 1'b1;
            IDX_INC:        n_idx = r_idx + 1'b1;
            default:        n_idx = r_idx;
        endcase
    end

    assign w_rd_idx  = i_cmd.rd_below ? (n_idx - 1'b1) : n_idx;
    assign w_rd_addr = w_rd_idx[AW-1:0];
    assign w_wr_addr = r_idx[AW-1:0];

    always_comb begin
        w_wr_data = r_rd;
        case (i_cmd.wr_sel)
            WR_NEW: begin
                w_wr_data.tag       = r_tag;
                w_wr_data.prio      = r_prio;
                w_wr_data.period    = r_period;
                w_wr_data.remaining = r_period;
            end
            WR_TICK: begin
                // expired entry reloads, others count down
                if (r_rd.remaining == '0) begin
                    w_wr_data.remaining = r_rd.period;
                end else begin
                    w_wr_data.remaining = r_rd.remaining - 1'b1;
                end
            end
            default: begin
                w_wr_data = r_rd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.pend_clr) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_tag    <= i_handler_id;
            r_prio   <= i_prio;
            r_period <= i_period_ticks;
        end
        if (i_cmd.pend_load) begin
            r_pend_tag <= r_rd.tag;
        end
        if (i_cmd.push) begin
            r_out_kind <= i_cmd.push_kind;
            r_out_id   <= i_cmd.push_pend ? r_pend_tag : '0;
            r_out_last <= i_cmd.push_last;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(SLOTS));
    assign o_stat.idx_last   = ((r_idx + 1'b1) == r_count);
    assign o_stat.idx_one    = (r_idx == CW'(1));
    assign o_stat.prio_ge    = (r_rd.prio >= r_prio);
    assign o_stat.rem_zero   = (r_rd.remaining == '0);
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_fired_id    = r_out_id;
    assign o_last        = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("entry count beyond table size");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> w_out_free)
        else $error("result pushed over an untaken beat");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_out_valid)
        else $error("pushed result not presented");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (r_idx < CW'(SLOTS)))
        else $error("slot write out of range");

    a_rd_wr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && i_cmd.wr_en) |-> (w_rd_addr != w_wr_addr))
        else $error("read and write hit the same slot");

endmodule

`default_nettype wire

### design/priority_periodic_timer_table.sv
// Top level of the priority-ordered periodic timer table.
`default_nettype none

// Periodic timer table: up to SLOTS handlers held in a single-port-write,
// single-port-read slot memory, packed from slot 0 and sorted by ascending
// priority (a new handler goes ahead of equal priorities). Each command beat
// with a used func code gives one or more result beats; the final one
// carries last. On register, the memory walk moves one entry up per cycle
// from the tail to the insert point; a full table answers full with no walk.
// On tick, one slot is read, updated and written back per cycle unless the
// sweep pauses for the result side; an empty table answers none with no
// sweep. The unused func code is dropped with no beat. The memory port pair
// gives one read and one write per cycle.
// Firings are held one deep so the last one can be flagged; when the result
// side stalls, the sweep pauses at the next firing slot. A new command is
// taken only when the previous one has produced all its results into the
// output register; that register lets the next command start while the
// final result still waits to be taken. No clearing pass is needed after
// reset: only slots below the entry count are ever read.
module priority_periodic_timer_table import ppt_pkg::*; #(
    parameter int SLOTS = PPT_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppt_cmd_if.sink   i_cmd,
    ppt_res_if.source o_res
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: decodes func, walks the table, pushes results
    ppt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_func  (i_cmd.func),
        .o_ready (i_cmd.ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // slot store, counters and output beat register
    ppt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_handler_id   (i_cmd.handler_id),
        .i_prio         (i_cmd.prio),
        .i_period_ticks (i_cmd.period_ticks),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_result_kind  (o_res.result_kind),
        .o_fired_id     (o_res.fired_id),
        .o_last         (o_res.last)
    );

endmodule

`default_nettype wire
